// File: rtl/aqnc_pkg.sv
`default_nettype none

package aqnc_pkg;

	// width of range bounds and of the numerator and span
	localparam int VAL_W = 16;
	// width of one packed centroid field, always Q0.10
	localparam int CENT_W = 10;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAS_RANGE         = 3'd0,
		CFG_TEMP_RANGE        = 3'd1,
		CFG_HUM_RANGE         = 3'd2,
		CFG_CENTROID_GOOD     = 3'd3,
		CFG_CENTROID_MODERATE = 3'd4,
		CFG_CENTROID_BAD      = 3'd5
	} cfg_idx_t;

	typedef enum logic [1:0] {
		LVL_GOOD     = 2'd0,
		LVL_MODERATE = 2'd1,
		LVL_BAD      = 2'd2
	} level_t;

	localparam logic [1:0] CLUSTER_GOOD     = 2'd0;
	localparam logic [1:0] CLUSTER_MODERATE = 2'd1;
	localparam logic [1:0] CLUSTER_BAD      = 2'd2;

	// one feature ready for division: zero forces 0, sat forces full scale
	typedef struct packed {
		logic [VAL_W-1:0] num;
		logic [VAL_W-1:0] span;
		logic             zero;
		logic             sat;
	} feat_t;

endpackage

`default_nettype wire

// File: rtl/aqnc_prep.sv
`default_nettype none

module aqnc_prep
	import aqnc_pkg::*;
(
	input  logic               clk,
	input  logic               adv,
	input  logic [11:0]        gas_raw,
	input  logic signed [10:0] temp_tenths,
	input  logic [9:0]         hum_tenths,
	input  logic               climate_valid,
	input  logic [31:0]        gas_range,
	input  logic [31:0]        temp_range,
	input  logic [31:0]        hum_range,
	output feat_t              gas_s1,
	output feat_t              temp_s1,
	output feat_t              hum_s1,
	output level_t             level_s1
);

	localparam logic signed [10:0] FALLBACK_TEMP = 11'sd280;
	localparam logic [9:0]         FALLBACK_HUM  = 10'd600;
	localparam logic [11:0]        GAS_GOOD_LIM  = 12'd300;
	localparam logic [11:0]        GAS_BAD_LIM   = 12'd1000;
	localparam logic signed [10:0] TEMP_LO       = 11'sd200;
	localparam logic signed [10:0] TEMP_HI       = 11'sd370;
	localparam logic [9:0]         HUM_LO        = 10'd400;
	localparam logic [9:0]         HUM_HI        = 10'd600;

	function automatic feat_t prep_feat(
		input logic signed [VAL_W:0] x,
		input logic signed [VAL_W:0] mn,
		input logic signed [VAL_W:0] mx
	);
		logic signed [VAL_W:0] num;
		logic signed [VAL_W:0] span;
		feat_t f;
		num    = x - mn;
		span   = mx - mn;
		f.num  = num[VAL_W-1:0];
		f.span = span[VAL_W-1:0];
		f.zero = span[VAL_W] || (span == '0) || num[VAL_W] || (num == '0);
		f.sat  = num >= span;
		return f;
	endfunction

	logic signed [10:0] t_sel;
	logic [9:0]         h_sel;
	logic               t_ok;
	logic               h_ok;
	level_t             level_d;

	assign t_sel = climate_valid ? temp_tenths : FALLBACK_TEMP;
	assign h_sel = climate_valid ? hum_tenths : FALLBACK_HUM;
	assign t_ok  = (t_sel >= TEMP_LO) && (t_sel <= TEMP_HI);
	assign h_ok  = (h_sel >= HUM_LO) && (h_sel <= HUM_HI);

	always_comb begin
		priority if ((gas_raw < GAS_GOOD_LIM) && t_ok && h_ok) begin
			level_d = LVL_GOOD;
		end else if ((gas_raw > GAS_BAD_LIM) || (!t_ok && !h_ok)) begin
			level_d = LVL_BAD;
		end else begin
			level_d = LVL_MODERATE;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			gas_s1   <= prep_feat({5'b0, gas_raw},
				{1'b0, gas_range[15:0]}, {1'b0, gas_range[31:16]});
			temp_s1  <= prep_feat({{6{t_sel[10]}}, t_sel},
				{temp_range[15], temp_range[15:0]}, {temp_range[31], temp_range[31:16]});
			hum_s1   <= prep_feat({7'b0, h_sel},
				{1'b0, hum_range[15:0]}, {1'b0, hum_range[31:16]});
			level_s1 <= level_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/aqnc_div.sv
`default_nettype none

module aqnc_div
	import aqnc_pkg::*;
#(
	parameter int FRAC_BITS = 10
) (
	input  logic               clk,
	input  logic               adv,
	input  feat_t              feat_in,
	output logic [FRAC_BITS:0] q_out
);

	// restoring division, one quotient bit per stage; num < span on the useful path
	logic [VAL_W-1:0]     rem_s  [1:FRAC_BITS];
	logic [VAL_W-1:0]     span_s [1:FRAC_BITS];
	logic [FRAC_BITS-1:0] quo_s  [1:FRAC_BITS];
	logic                 zero_s [1:FRAC_BITS];
	logic                 sat_s  [1:FRAC_BITS];

	for (genvar k = 0; k < FRAC_BITS; k++) begin : g_step
		logic [VAL_W-1:0]     rem_in;
		logic [VAL_W-1:0]     span_in;
		logic [FRAC_BITS-1:0] quo_in;
		logic                 zero_in;
		logic                 sat_in;
		logic [VAL_W:0]       dbl;
		logic [VAL_W+1:0]     diff;
		logic                 take;

		if (k == 0) begin : g_first
			assign rem_in  = feat_in.num;
			assign span_in = feat_in.span;
			assign quo_in  = '0;
			assign zero_in = feat_in.zero;
			assign sat_in  = feat_in.sat;
		end else begin : g_next
			assign rem_in  = rem_s[k];
			assign span_in = span_s[k];
			assign quo_in  = quo_s[k];
			assign zero_in = zero_s[k];
			assign sat_in  = sat_s[k];
		end

		assign dbl  = {rem_in, 1'b0};
		assign diff = {1'b0, dbl} - {2'b0, span_in};
		assign take = !diff[VAL_W+1];

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k+1]  <= take ? diff[VAL_W-1:0] : dbl[VAL_W-1:0];
				span_s[k+1] <= span_in;
				quo_s[k+1]  <= {quo_in[FRAC_BITS-2:0], take};
				zero_s[k+1] <= zero_in;
				sat_s[k+1]  <= sat_in;
			end
		end
	end

	always_comb begin
		priority if (zero_s[FRAC_BITS]) begin
			q_out = '0;
		end else if (sat_s[FRAC_BITS]) begin
			q_out = {1'b1, {FRAC_BITS{1'b0}}};
		end else begin
			q_out = {1'b0, quo_s[FRAC_BITS]};
		end
	end

endmodule

`default_nettype wire

// File: rtl/aqnc_dist.sv
`default_nettype none

module aqnc_dist
	import aqnc_pkg::*;
#(
	parameter int FRAC_BITS = 10
) (
	input  logic                  clk,
	input  logic                  adv,
	input  logic [FRAC_BITS:0]    feat [3],
	input  logic [3*CENT_W-1:0]   centroid [3],
	output logic [1:0]            cluster_s3
);

	localparam int FW   = FRAC_BITS + 1;
	localparam int SQW  = 2 * FW;
	localparam int DW   = SQW + 2;
	localparam int SH_L = (FRAC_BITS >= CENT_W) ? FRAC_BITS - CENT_W : 0;
	localparam int SH_R = (FRAC_BITS >= CENT_W) ? 0 : CENT_W - FRAC_BITS;

	logic [FW-1:0]  cs;
	logic [FW:0]    diff;
	logic [FW-1:0]  mag;
	logic [SQW-1:0] sq_d  [3][3];
	logic [SQW-1:0] sq_s1 [3][3];
	logic [DW-1:0]  dist_s2 [3];
	logic [DW-1:0]  best;
	logic [1:0]     pick;

	// stage 1: nine absolute differences squared
	always_comb begin
		cs   = '0;
		diff = '0;
		mag  = '0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				// shift at full width so a narrow scale drops only the low bits
				cs   = FW'((32'(centroid[i][j*CENT_W +: CENT_W]) << SH_L) >> SH_R);
				diff = {1'b0, feat[j]} - {1'b0, cs};
				mag  = diff[FW] ? FW'(-diff) : diff[FW-1:0];
				sq_d[i][j] = mag * mag;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s1 <= sq_d;
		end
	end

	// stage 2: squared distance per centroid
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				dist_s2[i] <= DW'(sq_s1[i][0]) + DW'(sq_s1[i][1]) + DW'(sq_s1[i][2]);
			end
		end
	end

	// stage 3: strict less-than keeps the lower index on ties
	always_comb begin
		if (dist_s2[1] < dist_s2[0]) begin
			pick = CLUSTER_MODERATE;
			best = dist_s2[1];
		end else begin
			pick = CLUSTER_GOOD;
			best = dist_s2[0];
		end
		if (dist_s2[2] < best) begin
			pick = CLUSTER_BAD;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cluster_s3 <= pick;
		end
	end

endmodule

`default_nettype wire

// File: rtl/air_quality_nearest_centroid.sv
// channel  | handshake               | payload
// ---------+-------------------------+-------------------------------------------------
// in       | in_valid / in_stall     | gas_raw, temp_tenths, hum_tenths, climate_valid
// out      | out_valid / out_stall   | cluster_index, threshold_level
// cfg      | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// one reading per cycle while the pipe is not stalled; the restoring
// divider spends one stage per quotient bit
// reset clears the valid line and loads default ranges and centroids
// a stalled result freezes the whole pipe, so in_stall follows out_stall while out_valid is high
`default_nettype none

module air_quality_nearest_centroid
	import aqnc_pkg::*;
#(
	parameter int NORM_FRAC_BITS = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [11:0]          gas_raw,
	input  logic signed [10:0]   temp_tenths,
	input  logic [9:0]           hum_tenths,
	input  logic                 climate_valid,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           cluster_index,
	output logic [1:0]           threshold_level,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	localparam int LAT = NORM_FRAC_BITS + 4;

	localparam logic [31:0]         GAS_RANGE_RST  = 32'd229376200;
	localparam logic [31:0]         TEMP_RANGE_RST = 32'd32768100;
	localparam logic [31:0]         HUM_RANGE_RST  = 32'd58982600;
	localparam logic [3*CENT_W-1:0] CENT_GOOD_RST  = 30'd644350157;
	localparam logic [3*CENT_W-1:0] CENT_MOD_RST   = 30'd537500160;
	localparam logic [3*CENT_W-1:0] CENT_BAD_RST   = 30'd430651238;

	logic                      adv;
	logic [31:0]               gas_range_q;
	logic [31:0]               temp_range_q;
	logic [31:0]               hum_range_q;
	logic [3*CENT_W-1:0]       cent_q [3];
	logic [LAT:1]              vld_s;
	level_t                    lvl_s [2:LAT];
	feat_t                     gas_s1;
	feat_t                     temp_s1;
	feat_t                     hum_s1;
	level_t                    level_s1;
	logic [NORM_FRAC_BITS:0]   feat [3];
	logic [1:0]                cluster;

	// the pipe moves unless a finished result is held
	assign adv       = !(vld_s[LAT] && out_stall);
	assign in_stall  = !adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gas_range_q  <= GAS_RANGE_RST;
			temp_range_q <= TEMP_RANGE_RST;
			hum_range_q  <= HUM_RANGE_RST;
			cent_q[0]    <= CENT_GOOD_RST;
			cent_q[1]    <= CENT_MOD_RST;
			cent_q[2]    <= CENT_BAD_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_GAS_RANGE:         gas_range_q  <= cfg_data;
				CFG_TEMP_RANGE:        temp_range_q <= cfg_data;
				CFG_HUM_RANGE:         hum_range_q  <= cfg_data;
				CFG_CENTROID_GOOD:     cent_q[0]    <= cfg_data[3*CENT_W-1:0];
				CFG_CENTROID_MODERATE: cent_q[1]    <= cfg_data[3*CENT_W-1:0];
				CFG_CENTROID_BAD:      cent_q[2]    <= cfg_data[3*CENT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[LAT-1:1], in_valid};
		end
	end

	// level_s1 sits in stage 1, so the delay line starts at stage 2
	always_ff @(posedge clk) begin
		if (adv) begin
			lvl_s[2] <= level_s1;
			for (int k = 3; k <= LAT; k++) begin
				lvl_s[k] <= lvl_s[k-1];
			end
		end
	end

	aqnc_prep u_prep (
		.clk           (clk),
		.adv           (adv),
		.gas_raw       (gas_raw),
		.temp_tenths   (temp_tenths),
		.hum_tenths    (hum_tenths),
		.climate_valid (climate_valid),
		.gas_range     (gas_range_q),
		.temp_range    (temp_range_q),
		.hum_range     (hum_range_q),
		.gas_s1        (gas_s1),
		.temp_s1       (temp_s1),
		.hum_s1        (hum_s1),
		.level_s1      (level_s1)
	);

	aqnc_div #(.FRAC_BITS(NORM_FRAC_BITS)) u_div_gas (
		.clk     (clk),
		.adv     (adv),
		.feat_in (gas_s1),
		.q_out   (feat[0])
	);

	aqnc_div #(.FRAC_BITS(NORM_FRAC_BITS)) u_div_temp (
		.clk     (clk),
		.adv     (adv),
		.feat_in (temp_s1),
		.q_out   (feat[1])
	);

	aqnc_div #(.FRAC_BITS(NORM_FRAC_BITS)) u_div_hum (
		.clk     (clk),
		.adv     (adv),
		.feat_in (hum_s1),
		.q_out   (feat[2])
	);

	aqnc_dist #(.FRAC_BITS(NORM_FRAC_BITS)) u_dist (
		.clk        (clk),
		.adv        (adv),
		.feat       (feat),
		.centroid   (cent_q),
		.cluster_s3 (cluster)
	);

	assign out_valid       = vld_s[LAT];
	assign cluster_index   = cluster;
	assign threshold_level = lvl_s[LAT];

`ifndef NO_ASSERTIONS
	a_cluster_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cluster_index == CLUSTER_GOOD || cluster_index == CLUSTER_MODERATE
			|| cluster_index == CLUSTER_BAD))
		else $error("cluster index out of range");

	a_pipe_holds: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> $stable(vld_s))
		else $error("valid line moved while stalled");

	a_request_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> vld_s[1])
		else $error("accepted request missing from first stage");
`endif

endmodule

`default_nettype wire
